@@ hdl/box_blur_3x3_rgb_unit_assert.svh @@
// Assertion macros shared by the front end and queue modules of the blur unit.
`ifndef BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define BB3_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ hdl/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and arithmetic helpers of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int NUM_W      = 13;
  localparam int RECIP_W    = 20;
  localparam int RECIP_SH   = 20;
  localparam int PROD_W     = NUM_W + RECIP_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int QUEUE_DEPTH  = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bb3_reg_t;

  // Front end sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } bb3_state_t;

  // Neighborhood sums of one result, waiting for the divide.
  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]      cnt;
    logic                  frame_end;
  } bb3_acc_t;

  // Adds the selected rows of one window column (bit 0 is the top row).
  function automatic bb3_acc_t col_add(bb3_acc_t a, logic [2:0][PIX_W-1:0] col,
                                       logic [2:0] rows);
    bb3_acc_t r;
    r = a;
    for (int i = 0; i < 3; i++) begin
      if (rows[i]) begin
        for (int ch = 0; ch < 3; ch++) begin
          r.sum[ch] = r.sum[ch] + SUM_W'(col[i][PIX_W-1-CH_W*ch -: CH_W]);
        end
        r.cnt = r.cnt + CNT_W'(1);
      end
    end
    return r;
  endfunction

  // Rounded-up reciprocal of twice the count, scaled by 2^RECIP_SH.
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd5:    m = 20'd104858;
      4'd6:    m = 20'd87382;
      4'd7:    m = 20'd74899;
      4'd8:    m = 20'd65536;
      4'd9:    m = 20'd58255;
      default: m = 20'd524288;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/bb3_in_if.sv @@
// ----------------------------------------------------------------------------
// bb3_in_if
// Input channel of the blur unit: pixels and drain ticks.
// ----------------------------------------------------------------------------
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

@@ hdl/bb3_out_if.sv @@
// ----------------------------------------------------------------------------
// bb3_out_if
// Output channel of the blur unit: blurred pixels.
// ----------------------------------------------------------------------------
interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

@@ hdl/bb3_ram.sv @@
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bb3_front.sv @@
// ----------------------------------------------------------------------------
// bb3_front
// Accepts pixels and drain ticks, tracks frame position, reads and updates
// the line stores and forms the neighborhood sums of up to two results.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_unit_assert.svh"

module bb3_front #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT,
  parameter int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  bb3_in_if.sink                          in_ch,
  input  logic                            cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]       cfg_data,
  output logic                            ram_re,
  output logic [AW-1:0]                   ram_raddr,
  input  logic [bb3_pkg::PIX_W-1:0]       above_rdata,
  input  logic [bb3_pkg::PIX_W-1:0]       two_rdata,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic [bb3_pkg::PIX_W-1:0]       above_wdata,
  output logic [bb3_pkg::PIX_W-1:0]       two_wdata,
  output logic                            push0,
  output logic                            push1,
  output bb3_pkg::bb3_acc_t               push0_data,
  output bb3_pkg::bb3_acc_t               push1_data,
  input  logic [2:0]                      q_free
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  bb3_pkg::bb3_state_t state, state_next;

  logic [bb3_pkg::FW_W-1:0]  frame_width;
  logic [bb3_pkg::FH_W-1:0]  frame_height;
  logic [AW-1:0]             col_pos;
  logic [HW-1:0]             row_pos;
  logic [AW-1:0]             drain_pos;
  logic                      draining;
  logic [2:0][bb3_pkg::PIX_W-1:0] win0, win1;
  logic                      item_drain;
  logic [bb3_pkg::PIX_W-1:0] item_pix;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          accept, item_ok, room, fire;
  logic [AW-1:0] pos;
  logic          pos_ge1, pos_ge2, last_col, has_a, has_b;
  logic [2:0]    rows;
  logic [2:0][bb3_pkg::PIX_W-1:0] col;
  bb3_pkg::bb3_acc_t res_a, res_b;

  // Effective frame size, clamped to the supported range.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  // Classification: ignored items are taken and dropped at once.
  assign accept  = in_ch.valid && in_ch.ready;
  assign item_ok = in_ch.req_type ? draining : !draining;
  assign room    = q_free >= 3'd2;
  assign fire    = (state == bb3_pkg::ST_EMIT) && room;

  // Window geometry of the held item.
  assign pos      = item_drain ? drain_pos : col_pos;
  assign pos_ge1  = pos != '0;
  assign pos_ge2  = WW'(pos) >= WW'(2);
  assign last_col = (WW'(pos) + WW'(1)) == w_eff;
  assign has_a    = (item_drain || row_pos != '0) && pos_ge1;
  assign has_b    = (item_drain || row_pos != '0) && last_col;

  always_comb begin
    if (item_drain) begin
      rows = (h_eff >= HW'(2)) ? 3'b011 : 3'b010;
    end else begin
      rows = (row_pos >= HW'(2)) ? 3'b111 : 3'b110;
    end
  end

  assign col[0] = two_rdata;
  assign col[1] = above_rdata;
  assign col[2] = item_drain ? '0 : item_pix;

  // Neighborhood sums of the two possible results.
  always_comb begin
    res_a = bb3_pkg::col_add('0, win0, rows & {3{pos_ge2}});
    res_a = bb3_pkg::col_add(res_a, win1, rows);
    res_a = bb3_pkg::col_add(res_a, col, rows);
    res_a.frame_end = 1'b0;
    res_b = bb3_pkg::col_add('0, win1, rows & {3{pos_ge1}});
    res_b = bb3_pkg::col_add(res_b, col, rows);
    res_b.frame_end = item_drain;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bb3_pkg::ST_IDLE: begin
        if (accept && item_ok) begin
          state_next = bb3_pkg::ST_EMIT;
        end
      end
      bb3_pkg::ST_EMIT: begin
        if (room) begin
          state_next = bb3_pkg::ST_IDLE;
        end
      end
      default: state_next = bb3_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready = state == bb3_pkg::ST_IDLE;
    ram_re      = accept && item_ok;
    ram_raddr   = in_ch.req_type ? drain_pos : col_pos;
    ram_we      = fire && !item_drain;
    ram_waddr   = pos;
    above_wdata = item_pix;
    two_wdata   = above_rdata;
    push0       = fire && (has_a || has_b);
    push1       = fire && has_a && has_b;
    push0_data  = has_a ? res_a : res_b;
    push1_data  = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Held item payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_drain <= in_ch.req_type;
      item_pix   <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
    end
  end

  // Configuration registers and frame position.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::FW_W'(bb3_pkg::RESET_WIDTH);
      frame_height <= bb3_pkg::FH_W'(bb3_pkg::RESET_HEIGHT);
      col_pos      <= '0;
      row_pos      <= '0;
      drain_pos    <= '0;
      draining     <= 1'b0;
      win0         <= '0;
      win1         <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[bb3_pkg::FW_W-1:0];
      end else begin
        frame_height <= cfg_data;
      end
      col_pos   <= '0;
      row_pos   <= '0;
      drain_pos <= '0;
      draining  <= 1'b0;
      win0      <= '0;
      win1      <= '0;
    end else if (fire) begin
      win0 <= win1;
      win1 <= col;
      if (item_drain) begin
        if (last_col) begin
          col_pos   <= '0;
          row_pos   <= '0;
          drain_pos <= '0;
          draining  <= 1'b0;
          win0      <= '0;
          win1      <= '0;
        end else begin
          drain_pos <= drain_pos + AW'(1);
        end
      end else if (last_col) begin
        col_pos <= '0;
        row_pos <= row_pos + HW'(1);
        if ((row_pos + HW'(1)) >= h_eff) begin
          draining <= 1'b1;
        end
      end else begin
        col_pos <= col_pos + AW'(1);
      end
    end
  end

  `BB3_ASSERT(a_col_in_frame, WW'(col_pos) < w_eff, "column position beyond frame width")
  `BB3_ASSERT(a_drain_only_when_draining, drain_pos != '0 |-> draining, "drain position moved outside flush")
  `BB3_ASSERT(a_ignored_item_stays_idle, accept && !item_ok && !cfg_we |=> state == bb3_pkg::ST_IDLE && $stable(col_pos), "ignored item changed state")

endmodule

@@ hdl/bb3_queue.sv @@
// ----------------------------------------------------------------------------
// bb3_queue
// Short queue of neighborhood sums between front and back; takes up to two
// entries per cycle and releases one when the back end pops.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_unit_assert.svh"

module bb3_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  logic              push1,
  input  bb3_pkg::bb3_acc_t push0_data,
  input  bb3_pkg::bb3_acc_t push1_data,
  output logic [2:0]        q_free,
  input  logic              pop,
  output logic              head_valid,
  output bb3_pkg::bb3_acc_t head_data
);

  localparam int PW = $clog2(bb3_pkg::QUEUE_DEPTH);

  bb3_pkg::bb3_acc_t entries [bb3_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [2:0]    count;
  logic [2:0]    count_next;
  logic          do_pop;

  assign do_pop     = pop && head_valid;
  assign head_valid = count != 3'd0;
  assign head_data  = entries[rd_ptr];
  assign q_free     = 3'(bb3_pkg::QUEUE_DEPTH) - count;
  assign count_next = count + 3'(push0) + 3'(push1) - 3'(do_pop);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= push0_data;
    end
    if (push1) begin
      entries[wr_ptr + PW'(1)] <= push1_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push0) + PW'(push1);
      rd_ptr <= rd_ptr + PW'(do_pop);
      count  <= count_next;
    end
  end

  `BB3_NEVER(a_no_overflow, (push0 || push1) && q_free < 3'd2, "push into a queue without room")
  `BB3_NEVER(a_push_order, push1 && !push0, "second entry pushed without the first")
  `BB3_NEVER(a_count_bound, count > 3'(bb3_pkg::QUEUE_DEPTH), "queue fill level beyond depth")

endmodule

@@ hdl/bb3_back.sv @@
// ----------------------------------------------------------------------------
// bb3_back
// Divides the channel sums by the pixel count with rounding, through a
// reciprocal table and one multiply per channel, into the output register.
// ----------------------------------------------------------------------------
module bb3_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  bb3_pkg::bb3_acc_t head_data,
  output logic              pop,
  bb3_out_if.source         out_ch
);

  logic [2:0][bb3_pkg::PROD_W-1:0] prod;
  logic                            fe;
  logic                            vld;
  logic [bb3_pkg::RECIP_W-1:0]     m;

  assign pop = head_valid && (!vld || out_ch.ready);
  assign m   = bb3_pkg::recip(head_data.cnt);

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (pop) begin
      vld <= 1'b1;
    end else if (out_ch.ready) begin
      vld <= 1'b0;
    end
  end

  // (2*sum + count) times the reciprocal of 2*count, one lane per channel.
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod[ch] <= bb3_pkg::PROD_W'({head_data.sum[ch], 1'b0} +
                    bb3_pkg::NUM_W'(head_data.cnt)) * bb3_pkg::PROD_W'(m);
      end
      fe <= head_data.frame_end;
    end
  end

  assign out_ch.valid     = vld;
  assign out_ch.out_red   = prod[0][bb3_pkg::RECIP_SH +: bb3_pkg::CH_W];
  assign out_ch.out_green = prod[1][bb3_pkg::RECIP_SH +: bb3_pkg::CH_W];
  assign out_ch.out_blue  = prod[2][bb3_pkg::RECIP_SH +: bb3_pkg::CH_W];
  assign out_ch.frame_end = fe;

endmodule

@@ hdl/box_blur_3x3_rgb_unit.sv @@
// A result passes from the held transaction through the queue into the back end
// output register. The front end takes no new transaction until the line store read
// and update of the last one is done; an ignored transaction is dropped at once.
// Results drain at one per cycle while the output is ready, from the back end
// through a four-entry queue. Reset is synchronous: positions clear, size returns
// to 640 x 480, and the line stores keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit
// Streaming 3x3 box blur over RGB pixels in raster order, with edge-aware
// rounded means and drain ticks that flush the final row.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  bb3_in_if.sink                        in_ch,
  bb3_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                      ram_re, ram_we;
  logic [AW-1:0]             ram_raddr, ram_waddr;
  logic [bb3_pkg::PIX_W-1:0] above_rdata, two_rdata, above_wdata, two_wdata;
  logic                      push0, push1, pop, head_valid;
  bb3_pkg::bb3_acc_t         push0_data, push1_data, head_data;
  logic [2:0]                q_free;

  // Line store of the row above.
  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(MAX_WIDTH), .AW(AW)) u_above (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(above_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(above_rdata)
  );

  // Line store of the row two above.
  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(MAX_WIDTH), .AW(AW)) u_two (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(two_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(two_rdata)
  );

  bb3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ram_re(ram_re), .ram_raddr(ram_raddr),
    .above_rdata(above_rdata), .two_rdata(two_rdata),
    .ram_we(ram_we), .ram_waddr(ram_waddr),
    .above_wdata(above_wdata), .two_wdata(two_wdata),
    .push0(push0), .push1(push1), .push0_data(push0_data), .push1_data(push1_data),
    .q_free(q_free)
  );

  bb3_queue u_queue (
    .clk(clk), .rst(rst),
    .push0(push0), .push1(push1), .push0_data(push0_data), .push1_data(push1_data),
    .q_free(q_free), .pop(pop), .head_valid(head_valid), .head_data(head_data)
  );

  bb3_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_data(head_data),
    .pop(pop), .out_ch(out_ch)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the 3x3 RGB box blur: a directed table followed by
// random frames of many sizes, with random gaps on both channels. Every
// blurred pixel is compared with a cycle-free model of the line stores.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;
  localparam int   TARGET_ITEMS = 1850;
  localparam int   CYCLE_LIMIT  = 2000000;
  localparam int   SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } blur_px_t;

  typedef enum {OP_CFG, OP_PIXEL, OP_DRAIN} row_op_t;

  typedef struct {
    row_op_t   op;
    bb3_pkg::bb3_reg_t index;
    int        value;
    logic [7:0] red, green, blue;
    bit        typed;
    blur_px_t  result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bb3_pkg::CFG_W-1:0] cfg_data = '0;

  bb3_in_if  in_bus();
  bb3_out_if out_bus();

  box_blur_3x3_rgb_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_bus), .out_ch(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Model state of the blur.
  localparam int MAX_WIDTH_M = bb3_pkg::DEF_MAX_WIDTH;
  logic [23:0] line_above [MAX_WIDTH_M];
  logic [23:0] line_two_above [MAX_WIDTH_M];
  logic [23:0] win [2][3];
  int col_pos, row_pos, drain_pos;
  bit draining;
  int width_reg = bb3_pkg::RESET_WIDTH, height_reg = bb3_pkg::RESET_HEIGHT;
  int acc_sum [3];
  int acc_cnt;

  blur_px_t expected_px [$];
  int errors = 0;
  int cycles = 0;
  int counted = 0;
  bit send_quiet = 0, recv_quiet = 0;

  function automatic int eff_width();
    return width_reg < 1 ? 1 :
           (width_reg > bb3_pkg::DEF_MAX_WIDTH ? bb3_pkg::DEF_MAX_WIDTH : width_reg);
  endfunction

  function automatic int eff_height();
    return height_reg < 1 ? 1 :
           (height_reg > bb3_pkg::DEF_MAX_HEIGHT ? bb3_pkg::DEF_MAX_HEIGHT : height_reg);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
    draining = 0;
    for (int i = 0; i < 2; i++) for (int j = 0; j < 3; j++) win[i][j] = '0;
  endfunction

  // Adds the selected rows of a column (bit 0 is the top row).
  function automatic void add_col(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
                                  logic [2:0] rows);
    logic [23:0] c [3];
    c[0] = c0; c[1] = c1; c[2] = c2;
    for (int i = 0; i < 3; i++) begin
      if (rows[i]) begin
        acc_sum[0] += int'(c[i][23:16]);
        acc_sum[1] += int'(c[i][15:8]);
        acc_sum[2] += int'(c[i][7:0]);
        acc_cnt++;
      end
    end
  endfunction

  function automatic void push_mean(bit fe);
    blur_px_t px;
    int n;
    n = acc_cnt ? acc_cnt : 1;
    px.red = 8'((2 * acc_sum[0] + n) / (2 * n));
    px.green = 8'((2 * acc_sum[1] + n) / (2 * n));
    px.blue = 8'((2 * acc_sum[2] + n) / (2 * n));
    px.frame_end = fe;
    expected_px.push_back(px);
  endfunction

  function automatic void clear_acc();
    acc_sum[0] = 0; acc_sum[1] = 0; acc_sum[2] = 0; acc_cnt = 0;
  endfunction

  // Means of the middle row centered on column pos-1 and, at the last column, on pos.
  function automatic int blur_column(int pos, int w, logic [23:0] c0, logic [23:0] c1,
                                     logic [23:0] c2, logic [2:0] rows, bit last_row);
    int k;
    k = 0;
    if (pos >= 1) begin
      clear_acc();
      if (pos >= 2) add_col(win[0][0], win[0][1], win[0][2], rows);
      add_col(win[1][0], win[1][1], win[1][2], rows);
      add_col(c0, c1, c2, rows);
      push_mean(1'b0);
      k++;
    end
    if (pos == w - 1) begin
      clear_acc();
      if (pos >= 1) add_col(win[1][0], win[1][1], win[1][2], rows);
      add_col(c0, c1, c2, rows);
      push_mean(last_row);
      k++;
    end
    win[0] = win[1];
    win[1][0] = c0; win[1][1] = c1; win[1][2] = c2;
    return k;
  endfunction

  // Advances the model by one transaction; returns -1 when it is ignored.
  function automatic int blur_step(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, h, c, d, k;
    logic [23:0] pix;
    w = eff_width();
    h = eff_height();
    k = 0;
    if (req == REQ_PIXEL) begin
      if (draining) return -1;
      c = col_pos >= w ? 0 : col_pos;
      pix = {r, g, b};
      if (row_pos >= 1) begin
        k = blur_column(c, w, line_two_above[c], line_above[c], pix,
                        row_pos >= 2 ? 3'b111 : 3'b110, 1'b0);
      end else begin
        win[0] = win[1];
        win[1][0] = line_two_above[c]; win[1][1] = line_above[c]; win[1][2] = pix;
      end
      line_two_above[c] = line_above[c];
      line_above[c] = pix;
      c++;
      if (c >= w) begin
        c = 0;
        row_pos++;
        if (row_pos >= h) draining = 1;
      end
      col_pos = c;
    end else begin
      if (!draining) return -1;
      d = drain_pos >= w ? 0 : drain_pos;
      k = blur_column(d, w, line_two_above[d], line_above[d], 24'd0,
                      h >= 2 ? 3'b011 : 3'b010, 1'b1);
      d++;
      if (d >= w) restart_frame();
      else drain_pos = d;
    end
    return k;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, then compare each transaction with the oldest
  // expectation.
  initial begin
    blur_px_t want;
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 49) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid === 1'b1 && !rst));
      if (expected_px.size() == 0) begin
        $error("unexpected blurred pixel %0h %0h %0h", out_bus.out_red,
               out_bus.out_green, out_bus.out_blue);
        errors++;
      end else begin
        want = expected_px.pop_front();
        if (out_bus.out_red !== want.red) begin
          $error("out_red expected %0d actual %0d", want.red, out_bus.out_red);
          errors++;
        end
        if (out_bus.out_green !== want.green) begin
          $error("out_green expected %0d actual %0d", want.green, out_bus.out_green);
          errors++;
        end
        if (out_bus.out_blue !== want.blue) begin
          $error("out_blue expected %0d actual %0d", want.blue, out_bus.out_blue);
          errors++;
        end
        if (out_bus.frame_end !== want.frame_end) begin
          $error("frame_end expected %0d actual %0d", want.frame_end, out_bus.frame_end);
          errors++;
        end
      end
    end
  end

  // Sends one transaction after a random gap and predicts its results.
  task automatic send_item(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           output int n);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.req_type <= req;
    in_bus.in_red <= r;
    in_bus.in_green <= g;
    in_bus.in_blue <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    n = blur_step(req, r, g, b);
    if (n >= 0) counted++;
  endtask

  // Holds the input until every result is out and the block has settled.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bb3_pkg::bb3_reg_t index, int value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= bb3_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == bb3_pkg::REG_FRAME_WIDTH) width_reg = value & 'h7FF;
    else height_reg = value & 'h1FFF;
    restart_frame();
  endtask

  stim_row_t table_rows [$];

  function automatic void add_row(row_op_t op, bb3_pkg::bb3_reg_t index, int value,
                                  int r, int g, int b, bit typed = 0,
                                  blur_px_t result = '0);
    stim_row_t s;
    s.op = op; s.index = index; s.value = value;
    s.red = 8'(r); s.green = 8'(g); s.blue = 8'(b);
    s.typed = typed; s.result = result;
    table_rows.push_back(s);
  endfunction

  initial begin
    int n, w, h, stop_at;
    bit aborted;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_PIXEL;
    in_bus.in_red = '0;
    in_bus.in_green = '0;
    in_bus.in_blue = '0;
    restart_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: ignored drain after reset, one-pixel frames, clamping,
    // a pixel while draining, a 3x3 frame of extremes, the largest sizes.
    add_row(OP_DRAIN, bb3_pkg::REG_FRAME_WIDTH, 0, 0, 0, 0);
    add_row(OP_CFG, bb3_pkg::REG_FRAME_WIDTH, 1, 0, 0, 0);
    add_row(OP_CFG, bb3_pkg::REG_FRAME_HEIGHT, 1, 0, 0, 0);
    add_row(OP_PIXEL, bb3_pkg::REG_FRAME_WIDTH, 0, 255, 255, 255);
    add_row(OP_DRAIN, bb3_pkg::REG_FRAME_WIDTH, 0, 0, 0, 0, 1,
            '{8'd255, 8'd255, 8'd255, 1'b1});
    add_row(OP_PIXEL, bb3_pkg::REG_FRAME_WIDTH, 0, 0, 0, 0);
    add_row(OP_PIXEL, bb3_pkg::REG_FRAME_WIDTH, 0, 12, 34, 56);
    add_row(OP_DRAIN, bb3_pkg::REG_FRAME_WIDTH, 0, 0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1});
    add_row(OP_CFG, bb3_pkg::REG_FRAME_WIDTH, 0, 0, 0, 0);
    add_row(OP_CFG, bb3_pkg::REG_FRAME_HEIGHT, 0, 0, 0, 0);
    add_row(OP_PIXEL, bb3_pkg::REG_FRAME_WIDTH, 0, 170, 85, 1);
    add_row(OP_DRAIN, bb3_pkg::REG_FRAME_WIDTH, 0, 0, 0, 0, 1,
            '{8'd170, 8'd85, 8'd1, 1'b1});
    add_row(OP_CFG, bb3_pkg::REG_FRAME_WIDTH, 3, 0, 0, 0);
    add_row(OP_CFG, bb3_pkg::REG_FRAME_HEIGHT, 3, 0, 0, 0);
    for (int i = 0; i < 9; i++)
      add_row(OP_PIXEL, bb3_pkg::REG_FRAME_WIDTH, 0, i[0] ? 255 : 0, i[1] ? 255 : 0,
              i % 3 ? 0 : 255);
    for (int i = 0; i < 3; i++) add_row(OP_DRAIN, bb3_pkg::REG_FRAME_WIDTH, 0, 0, 0, 0);
    add_row(OP_CFG, bb3_pkg::REG_FRAME_WIDTH, 2047, 0, 0, 0);
    add_row(OP_CFG, bb3_pkg::REG_FRAME_HEIGHT, 8191, 0, 0, 0);
    add_row(OP_PIXEL, bb3_pkg::REG_FRAME_WIDTH, 0, 1, 2, 4);
    add_row(OP_PIXEL, bb3_pkg::REG_FRAME_WIDTH, 0, 254, 253, 251);

    foreach (table_rows[i]) begin
      if (table_rows[i].op == OP_CFG) begin
        write_reg(table_rows[i].index, table_rows[i].value);
      end else begin
        send_item(table_rows[i].op == OP_DRAIN ? REQ_DRAIN : REQ_PIXEL,
                  table_rows[i].red, table_rows[i].green, table_rows[i].blue, n);
        if (table_rows[i].typed && n == 1) begin
          void'(expected_px.pop_back());
          expected_px.push_back(table_rows[i].result);
        end
      end
    end

    // Random frames, mostly small, with stray and cut-off sequences.
    while (counted < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(7, 40);
        1:       w = 1;
        default: w = $urandom_range(2, 6);
      endcase
      h = $urandom_range(0, 4) == 0 ? 1 : $urandom_range(2, 5);
      if (w != eff_width() || $urandom_range(0, 1)) write_reg(bb3_pkg::REG_FRAME_WIDTH, w);
      if (h != eff_height() || $urandom_range(0, 1)) write_reg(bb3_pkg::REG_FRAME_HEIGHT, h);
      send_quiet = $urandom_range(0, 3) == 0;
      aborted = 0;
      stop_at = $urandom_range(0, 14) == 0 ? $urandom_range(0, w * h - 1) : -1;
      for (int p = 0; p < w * h && !aborted; p++) begin
        if (p == stop_at) begin
          aborted = 1;
        end else begin
          if ($urandom_range(0, 29) == 0) send_item(REQ_DRAIN, '0, '0, '0, n);
          send_item(REQ_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), n);
        end
      end
      if (aborted) begin
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, h);
      end else begin
        for (int d = 0; d < w; d++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(REQ_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), n);
          send_item(REQ_DRAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), n);
        end
        // Now and then hold the sender until every result is back.
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
